// ----- hw/rtl/jbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_pkg
// Types, codes and the token-start decoder shared by the byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int MapWidth   = 32;
  localparam int CfgIdxW    = 2;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [MapWidth-1:0] MapReset0 = 32'h0000_0000;
  localparam logic [MapWidth-1:0] MapReset1 = 32'hf3ff_6838;
  localparam logic [MapWidth-1:0] MapReset2 = 32'h87ff_ffff;
  localparam logic [MapWidth-1:0] MapReset3 = 32'h47ff_fffe;

  localparam logic [CfgIdxW-1:0] CFG_MAP0 = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAP1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAP2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAP3 = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_STR   = 4'd1,
    MODE_ESC   = 4'd2,
    MODE_IDENT = 4'd3,
    MODE_SLASH = 4'd4,
    MODE_LINE  = 4'd5,
    MODE_BLOCK = 4'd6,
    MODE_STAR  = 4'd7,
    MODE_ERR   = 4'd8
  } lex_mode_t;

  localparam logic [3:0] KIND_CONTENT = 4'd0;
  localparam logic [3:0] KIND_LBRACE  = 4'd1;
  localparam logic [3:0] KIND_RBRACE  = 4'd2;
  localparam logic [3:0] KIND_LBRACK  = 4'd3;
  localparam logic [3:0] KIND_RBRACK  = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_COLON   = 4'd6;
  localparam logic [3:0] KIND_STR_END = 4'd7;
  localparam logic [3:0] KIND_ID_END  = 4'd8;
  localparam logic [3:0] KIND_EOF     = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_END     = 2'd1;
  localparam logic [1:0] ERR_COMMENT = 2'd2;
  localparam logic [1:0] ERR_INVALID = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] content;
    logic [1:0] error_code;
    logic       last;
  } tok_result_t;

  typedef struct packed {
    lex_mode_t   mode;
    logic        emit;
    tok_result_t res;
  } tok_start_t;

  function automatic tok_result_t mk_result(input logic [3:0] kind,
                                            input logic [7:0] content,
                                            input logic [1:0] err);
    tok_result_t r;
    r.kind       = kind;
    r.content    = (kind == KIND_CONTENT) ? content : 8'h00;
    r.error_code = (kind == KIND_ERROR) ? err : ERR_NONE;
    r.last       = 1'b0;
    return r;
  endfunction

  // Token start from idle: b is the byte, id_hit its identifier-map bit.
  function automatic tok_start_t start_token(input logic [7:0] b, input logic id_hit);
    tok_start_t s;
    s.mode = MODE_IDLE;
    s.emit = 1'b0;
    s.res  = mk_result(KIND_CONTENT, 8'h00, ERR_NONE);
    case (b) inside
      [CH_TAB:CH_CR], CH_SPACE: s.mode = MODE_IDLE;
      CH_LBRC: begin s.emit = 1'b1; s.res = mk_result(KIND_LBRACE, 8'h00, ERR_NONE); end
      CH_RBRC: begin s.emit = 1'b1; s.res = mk_result(KIND_RBRACE, 8'h00, ERR_NONE); end
      CH_LBRK: begin s.emit = 1'b1; s.res = mk_result(KIND_LBRACK, 8'h00, ERR_NONE); end
      CH_RBRK: begin s.emit = 1'b1; s.res = mk_result(KIND_RBRACK, 8'h00, ERR_NONE); end
      CH_COMMA: begin s.emit = 1'b1; s.res = mk_result(KIND_COMMA, 8'h00, ERR_NONE); end
      CH_COLON: begin s.emit = 1'b1; s.res = mk_result(KIND_COLON, 8'h00, ERR_NONE); end
      CH_QUOTE: s.mode = MODE_STR;
      default: begin
        if (id_hit) begin
          s.emit = 1'b1;
          s.res  = mk_result(KIND_CONTENT, b, ERR_NONE);
          s.mode = MODE_IDENT;
        end else if (b == CH_SLASH) begin
          s.mode = MODE_SLASH;
        end else begin
          s.emit = 1'b1;
          s.res  = mk_result(KIND_ERROR, 8'h00, ERR_INVALID);
          s.mode = MODE_ERR;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/jbt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_in_if / jbt_out_if
// Valid/ready channels for raw bytes in and tokens out.
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_mark;

  modport source (output valid, output byte_in, output end_mark, input ready);
  modport sink   (input valid, input byte_in, input end_mark, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] content;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output content, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input content, input error_code,
                  input last, output ready);
endinterface

// ----- hw/rtl/json_byte_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit
// Streaming JSON lexer, skips comments; one byte word per cycle if no stall.
// ----------------------------------------------------------------------------
//  channel   dir  words                          notes
//  in_bus    in   byte_in, end_mark              one byte or end of input
//  out_bus   out  kind, content, error_code, last 0..2 tokens per input word
//  cfg_*     in   index, 32-bit data             identifier map, write only
//
// An input word is registered, decoded combinationally against the lexer
// mode and its 0..2 tokens pushed into a 4-entry output queue; one word per
// cycle is sustained while each word yields at most one token and the sink
// takes a token each cycle. A token passes the input register and then the
// output queue. Decode waits while fewer than two queue slots are free.
// Synchronous active-low reset restores idle and the default identifier map.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  jbt_in_if.sink                      in_bus,
  jbt_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [jbt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [jbt_pkg::MapWidth-1:0] cfg_wdata
);

  logic [jbt_pkg::MapWidth-1:0] map0_r, map1_r, map2_r, map3_r;
  logic [4*jbt_pkg::MapWidth-1:0] map_all;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_fire;
  logic       in_fire;

  jbt_pkg::lex_mode_t mode_r, mode_nxt;
  jbt_pkg::tok_result_t res0, res1;
  jbt_pkg::tok_start_t st;
  logic [1:0] n_res;
  logic       id_hit;

  jbt_pkg::tok_result_t fifo_r [jbt_pkg::FifoDepth];
  logic [jbt_pkg::FifoPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [jbt_pkg::FifoCntW-1:0] cnt_r, cnt_nxt;
  logic pop;
  logic room;

  // identifier map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map0_r <= jbt_pkg::MapReset0;
      map1_r <= jbt_pkg::MapReset1;
      map2_r <= jbt_pkg::MapReset2;
      map3_r <= jbt_pkg::MapReset3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jbt_pkg::CFG_MAP0: map0_r <= cfg_wdata;
        jbt_pkg::CFG_MAP1: map1_r <= cfg_wdata;
        jbt_pkg::CFG_MAP2: map2_r <= cfg_wdata;
        jbt_pkg::CFG_MAP3: map3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign map_all = {map3_r, map2_r, map1_r, map0_r};
  assign id_hit  = !s1_byte_r[7] && map_all[s1_byte_r[6:0]];

  // input register
  assign room         = cnt_r <= jbt_pkg::FifoCntW'(jbt_pkg::FifoDepth - 2);
  assign s1_fire      = s1_valid_r && room;
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_bus.byte_in;
      s1_end_r  <= in_bus.end_mark;
    end
  end

  // lexer decode
  always_comb begin
    mode_nxt = mode_r;
    n_res    = 2'd0;
    res0     = jbt_pkg::mk_result(jbt_pkg::KIND_CONTENT, 8'h00, jbt_pkg::ERR_NONE);
    res1     = res0;
    st       = jbt_pkg::start_token(s1_byte_r, id_hit);
    if (s1_end_r) begin
      unique case (mode_r)
        jbt_pkg::MODE_ERR: ;
        jbt_pkg::MODE_IDLE, jbt_pkg::MODE_LINE: begin
          res0     = jbt_pkg::mk_result(jbt_pkg::KIND_EOF, 8'h00, jbt_pkg::ERR_NONE);
          n_res    = 2'd1;
          mode_nxt = jbt_pkg::MODE_IDLE;
        end
        jbt_pkg::MODE_IDENT: begin
          res0     = jbt_pkg::mk_result(jbt_pkg::KIND_ID_END, 8'h00, jbt_pkg::ERR_NONE);
          res1     = jbt_pkg::mk_result(jbt_pkg::KIND_EOF, 8'h00, jbt_pkg::ERR_NONE);
          n_res    = 2'd2;
          mode_nxt = jbt_pkg::MODE_IDLE;
        end
        jbt_pkg::MODE_SLASH: begin
          res0     = jbt_pkg::mk_result(jbt_pkg::KIND_ERROR, 8'h00, jbt_pkg::ERR_COMMENT);
          n_res    = 2'd1;
          mode_nxt = jbt_pkg::MODE_ERR;
        end
        default: begin
          res0     = jbt_pkg::mk_result(jbt_pkg::KIND_ERROR, 8'h00, jbt_pkg::ERR_END);
          n_res    = 2'd1;
          mode_nxt = jbt_pkg::MODE_ERR;
        end
      endcase
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_IDLE: begin
          res0     = st.res;
          n_res    = {1'b0, st.emit};
          mode_nxt = st.mode;
        end
        jbt_pkg::MODE_STR: begin
          if (s1_byte_r == jbt_pkg::CH_QUOTE) begin
            res0     = jbt_pkg::mk_result(jbt_pkg::KIND_STR_END, 8'h00, jbt_pkg::ERR_NONE);
            n_res    = 2'd1;
            mode_nxt = jbt_pkg::MODE_IDLE;
          end else if (s1_byte_r == jbt_pkg::CH_BSL) begin
            mode_nxt = jbt_pkg::MODE_ESC;
          end else begin
            res0  = jbt_pkg::mk_result(jbt_pkg::KIND_CONTENT, s1_byte_r, jbt_pkg::ERR_NONE);
            n_res = 2'd1;
          end
        end
        jbt_pkg::MODE_ESC: begin
          res0     = jbt_pkg::mk_result(jbt_pkg::KIND_CONTENT, s1_byte_r, jbt_pkg::ERR_NONE);
          n_res    = 2'd1;
          mode_nxt = jbt_pkg::MODE_STR;
        end
        jbt_pkg::MODE_IDENT: begin
          if (id_hit) begin
            res0  = jbt_pkg::mk_result(jbt_pkg::KIND_CONTENT, s1_byte_r, jbt_pkg::ERR_NONE);
            n_res = 2'd1;
          end else begin
            res0     = jbt_pkg::mk_result(jbt_pkg::KIND_ID_END, 8'h00, jbt_pkg::ERR_NONE);
            res1     = st.res;
            n_res    = st.emit ? 2'd2 : 2'd1;
            mode_nxt = st.mode;
          end
        end
        jbt_pkg::MODE_SLASH: begin
          if (s1_byte_r == jbt_pkg::CH_SLASH) begin
            mode_nxt = jbt_pkg::MODE_LINE;
          end else if (s1_byte_r == jbt_pkg::CH_STAR) begin
            mode_nxt = jbt_pkg::MODE_BLOCK;
          end else begin
            res0     = jbt_pkg::mk_result(jbt_pkg::KIND_ERROR, 8'h00, jbt_pkg::ERR_COMMENT);
            n_res    = 2'd1;
            mode_nxt = jbt_pkg::MODE_ERR;
          end
        end
        jbt_pkg::MODE_LINE: begin
          if (s1_byte_r == jbt_pkg::CH_LF) mode_nxt = jbt_pkg::MODE_IDLE;
        end
        jbt_pkg::MODE_BLOCK: begin
          if (s1_byte_r == jbt_pkg::CH_STAR) mode_nxt = jbt_pkg::MODE_STAR;
        end
        jbt_pkg::MODE_STAR: begin
          if (s1_byte_r == jbt_pkg::CH_SLASH) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
          end else if (s1_byte_r != jbt_pkg::CH_STAR) begin
            mode_nxt = jbt_pkg::MODE_BLOCK;
          end
        end
        default: mode_nxt = jbt_pkg::MODE_ERR;
      endcase
    end
    // last flag on the final token of the word
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jbt_pkg::MODE_IDLE;
    end else if (s1_fire) begin
      mode_r <= mode_nxt;
    end
  end

  // output queue
  assign pop = out_bus.valid && out_bus.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_fire) cnt_nxt = cnt_nxt + jbt_pkg::FifoCntW'(n_res);
    if (pop)     cnt_nxt = cnt_nxt - jbt_pkg::FifoCntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_fire) wr_ptr_r <= wr_ptr_r + jbt_pkg::FifoPtrW'(n_res);
      if (pop)     rd_ptr_r <= rd_ptr_r + jbt_pkg::FifoPtrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && n_res != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (s1_fire && n_res == 2'd2) fifo_r[wr_ptr_r + jbt_pkg::FifoPtrW'(1)] <= res1;
  end

  assign out_bus.valid      = cnt_r != '0;
  assign out_bus.kind       = fifo_r[rd_ptr_r].kind;
  assign out_bus.content    = fifo_r[rd_ptr_r].content;
  assign out_bus.error_code = fifo_r[rd_ptr_r].error_code;
  assign out_bus.last       = fifo_r[rd_ptr_r].last;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= jbt_pkg::FifoCntW'(jbt_pkg::FifoDepth))
    else $error("output queue overflow");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == jbt_pkg::MODE_ERR |=> mode_r == jbt_pkg::MODE_ERR)
    else $error("left error mode without reset");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && mode_r == jbt_pkg::MODE_ERR |-> n_res == 2'd0)
    else $error("token produced in error mode");

  a_pair_idend: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && n_res == 2'd2 |-> res0.kind == jbt_pkg::KIND_ID_END)
    else $error("token pair not led by identifier end");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !pop)
    else $error("pop from empty queue");

endmodule
